/* rtl/core/gcol_pkg.sv */
// Shared constants and types for the graph coloring block.
package gcol_pkg;

  localparam int MAX_NODES = 16;
  localparam int MAX_EDGES = 32;
  localparam int ID_BITS   = 8;

  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 6;
  localparam int NIDX_W   = $clog2(MAX_NODES);
  localparam int NCNT_W   = $clog2(MAX_NODES + 1);
  localparam int EIDX_W   = $clog2(MAX_EDGES);
  localparam int ECNT_W   = $clog2(MAX_EDGES + 1);
  localparam int TAKEN_W  = MAX_NODES + 2;
  localparam int COLOR_W  = $clog2(TAKEN_W);

  localparam logic [REQ_W-1:0] REQ_ADD_NODE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_EDGE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REM_NODE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_EDGE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEGREE   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_MAX_DEG  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_COLOR    = 3'd6;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd7;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REJECT    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [COLOR_W-1:0] color;
  } node_ent_t;

  typedef struct packed {
    logic [ID_BITS-1:0] first;
    logic [ID_BITS-1:0] second;
  } edge_ent_t;

endpackage

/* rtl/core/graph_edge_table_greedy_coloring.sv */
// Graph store with node and edge tables in synchronous memories and greedy coloring.
// Edits, degree and clear are served by a joint scan over both tables, reading nodes and edges together;
//   removals add a compaction sweep over both tables.
// Max degree scans the edge table once per node; coloring scans it at most once per node pair,
//   set by the single read port of the edge memory. One item is in work at a time.
// Reset clears the counts and the sequencer; table contents stay undefined until written.
module graph_edge_table_greedy_coloring import gcol_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [ID_BITS-1:0]  node_a_i,
  input  logic [ID_BITS-1:0]  node_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [VALUE_W-1:0]  value_o,
  output logic [ID_BITS-1:0]  node_id_o,
  output logic [NCNT_W-1:0]   node_count_o,
  output logic [ECNT_W-1:0]   edge_count_o,
  output logic                last_o
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_ADDB  = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_MD_N  = 4'd4;
  localparam logic [3:0] S_MD_W  = 4'd5;
  localparam logic [3:0] S_MD_E  = 4'd6;
  localparam logic [3:0] S_C_NI  = 4'd7;
  localparam logic [3:0] S_C_IW  = 4'd8;
  localparam logic [3:0] S_C_NJ  = 4'd9;
  localparam logic [3:0] S_C_JW  = 4'd10;
  localparam logic [3:0] S_C_E   = 4'd11;
  localparam logic [3:0] S_C_OUT = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  // Tables: one read and one write per cycle each, read data registered.
  // The sequencer never reads an entry in the cycle it writes that entry:
  // compaction writes strictly behind the read pointer.
  node_ent_t node_mem [MAX_NODES];
  edge_ent_t edge_mem [MAX_EDGES];
  node_ent_t n_rdata_q, n_wdata;
  edge_ent_t e_rdata_q, e_wdata;
  logic              n_re, n_we, e_re, e_we;
  logic [NIDX_W-1:0] n_raddr, n_waddr;
  logic [EIDX_W-1:0] e_raddr, e_waddr;

  logic [3:0]         state_q, state_d;
  logic [REQ_W-1:0]   req_q, req_d;
  logic [ID_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [NCNT_W-1:0]  nu_q, nu_d;       // nodes stored
  logic [ECNT_W-1:0]  eu_q, eu_d;       // edges stored
  logic [NCNT_W-1:0]  nc_q, nc_d;       // node read pointer
  logic               ndv_q, ndv_d;
  logic [NIDX_W-1:0]  ndi_q, ndi_d;
  logic [ECNT_W-1:0]  ec_q, ec_d;       // edge read pointer
  logic               edv_q, edv_d;
  logic [EIDX_W-1:0]  edi_q, edi_d;
  logic [ECNT_W-1:0]  kc_q, kc_d;       // edge compaction write pointer
  logic               fa_q, fa_d, fb_q, fb_d, ef_q, ef_d;
  logic [NIDX_W-1:0]  fai_q, fai_d;
  logic [EIDX_W-1:0]  efi_q, efi_d;
  logic [ECNT_W-1:0]  deg_q, deg_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [NCNT_W-1:0]  ci_q, ci_d, cj_q, cj_d;
  logic [ID_BITS-1:0] xid_q, xid_d, yid_q, yid_d;
  logic [COLOR_W-1:0] ycol_q, ycol_d;
  logic [TAKEN_W-1:0] taken_q, taken_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [VALUE_W-1:0]  out_value_q;
  logic [ID_BITS-1:0]  out_id_q;
  logic [NCNT_W-1:0]   out_nc_q;
  logic [ECNT_W-1:0]   out_ec_q;
  logic                out_last_q;

  logic                out_load, ol_last;
  logic [STATUS_W-1:0] ol_status;
  logic [VALUE_W-1:0]  ol_value;
  logic [ID_BITS-1:0]  ol_id;
  logic                slot_free;
  logic                n_more, e_more, n_idle, e_idle, scan_done, drop, hit;
  logic [NCNT_W:0]     nodes_needed;
  logic [COLOR_W-1:0]  free_col;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign n_more     = (nc_q < nu_q);
  assign e_more     = (ec_q < eu_q);
  assign n_idle     = !n_more && !ndv_q;
  assign e_idle     = !e_more && !edv_q;
  assign scan_done  = n_idle && e_idle;
  assign e_raddr    = ec_q[EIDX_W-1:0];
  assign nodes_needed = {1'b0, nu_q} + (NCNT_W+1)'(!fa_q) + (NCNT_W+1)'(!fb_q);
  assign hit = edv_q && (((e_rdata_q.first == xid_q) && (e_rdata_q.second == yid_q)) ||
                         ((e_rdata_q.first == yid_q) && (e_rdata_q.second == xid_q)));

  // Smallest color of 1 or more that no neighbor holds
  always_comb begin
    free_col = COLOR_W'(MAX_NODES + 1);
    for (int c = MAX_NODES; c >= 1; c--) begin
      if (!taken_q[c]) free_col = COLOR_W'(c);
    end
  end

  always_comb begin
    state_d = state_q; req_d = req_q; a_d = a_q; b_d = b_q;
    nu_d = nu_q; eu_d = eu_q;
    nc_d = nc_q; ndv_d = 1'b0; ndi_d = ndi_q;
    ec_d = ec_q; edv_d = 1'b0; edi_d = edi_q; kc_d = kc_q;
    fa_d = fa_q; fb_d = fb_q; ef_d = ef_q; fai_d = fai_q; efi_d = efi_q;
    deg_d = deg_q; st_d = st_q; val_d = val_q;
    ci_d = ci_q; cj_d = cj_q; xid_d = xid_q; yid_d = yid_q; ycol_d = ycol_q;
    taken_d = taken_q;
    n_re = 1'b0; n_raddr = nc_q[NIDX_W-1:0];
    n_we = 1'b0; n_waddr = nu_q[NIDX_W-1:0]; n_wdata = '{id: a_q, color: '0};
    e_re = 1'b0;
    e_we = 1'b0; e_waddr = eu_q[EIDX_W-1:0]; e_wdata = '{first: a_q, second: b_q};
    out_load = 1'b0; ol_status = st_q; ol_value = val_q; ol_id = '0; ol_last = 1'b1;
    drop = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = req_type_i; a_d = node_a_i; b_d = node_b_i;
          st_d = STAT_OK; val_d = '0;
          fa_d = 1'b0; fb_d = 1'b0; ef_d = 1'b0; deg_d = '0;
          nc_d = '0; ec_d = '0;
          state_d = S_SCAN;
        end
      end

      // Walk both tables at once: find node_a, node_b, the ordered edge, degree of node_a
      S_SCAN: begin
        if (ndv_q) begin
          if (n_rdata_q.id == a_q && !fa_q) begin
            fa_d = 1'b1; fai_d = ndi_q;
          end
          if (n_rdata_q.id == b_q) fb_d = 1'b1;
        end
        if (edv_q) begin
          if (e_rdata_q.first == a_q && e_rdata_q.second == b_q && !ef_q) begin
            ef_d = 1'b1; efi_d = edi_q;
          end
          if (e_rdata_q.first == a_q || e_rdata_q.second == a_q) deg_d = deg_q + 1'b1;
        end
        n_re = n_more; ndv_d = n_more; ndi_d = nc_q[NIDX_W-1:0];
        if (n_more) nc_d = nc_q + 1'b1;
        e_re = e_more; edv_d = e_more; edi_d = ec_q[EIDX_W-1:0];
        if (e_more) ec_d = ec_q + 1'b1;
        if (scan_done) begin
          state_d = S_EMIT;
          case (req_q)
            REQ_ADD_NODE: begin
              if (fa_q) st_d = STAT_REJECT;
              else if (nu_q == NCNT_W'(MAX_NODES)) st_d = STAT_FULL;
              else begin
                n_we = 1'b1; nu_d = nu_q + 1'b1;
              end
            end
            REQ_ADD_EDGE: begin
              if (a_q == b_q || ef_q) st_d = STAT_REJECT;
              else if (eu_q == ECNT_W'(MAX_EDGES) ||
                       nodes_needed > (NCNT_W+1)'(MAX_NODES)) st_d = STAT_FULL;
              else begin
                e_we = 1'b1; eu_d = eu_q + 1'b1;
                if (!fa_q) begin
                  n_we = 1'b1; nu_d = nu_q + 1'b1;
                  if (!fb_q) state_d = S_ADDB;
                end else if (!fb_q) begin
                  n_we = 1'b1; n_wdata = '{id: b_q, color: '0}; nu_d = nu_q + 1'b1;
                end
              end
            end
            REQ_REM_NODE: begin
              if (!fa_q) st_d = STAT_NOT_FOUND;
              else begin
                nc_d = {1'b0, fai_q} + 1'b1; ec_d = '0; kc_d = '0;
                state_d = S_SHIFT;
              end
            end
            REQ_REM_EDGE: begin
              if (!ef_q) st_d = STAT_NOT_FOUND;
              else begin
                nc_d = nu_q; ec_d = '0; kc_d = '0;
                state_d = S_SHIFT;
              end
            end
            REQ_DEGREE: begin
              if (!fa_q) st_d = STAT_NOT_FOUND;
              else val_d = VALUE_W'(deg_q);
            end
            REQ_MAX_DEG: begin
              ci_d = '0; state_d = S_MD_N;
            end
            REQ_COLOR: begin
              ci_d = '0;
              if (nu_q != '0) state_d = S_C_NI;
            end
            REQ_CLEAR: begin
              nu_d = '0; eu_d = '0;
            end
            default: ;
          endcase
        end
      end

      S_ADDB: begin
        n_we = 1'b1; n_wdata = '{id: b_q, color: '0}; nu_d = nu_q + 1'b1;
        state_d = S_EMIT;
      end

      // Drop edges and, for a node removal, close the gap in the node table in one sweep
      S_SHIFT: begin
        if (ndv_q) begin
          n_we = 1'b1; n_waddr = ndi_q - 1'b1; n_wdata = n_rdata_q;
        end
        if (edv_q) begin
          if (req_q == REQ_REM_NODE)
            drop = (e_rdata_q.first == a_q) || (e_rdata_q.second == a_q);
          else drop = (edi_q == efi_q);
          if (!drop) begin
            e_we = 1'b1; e_waddr = kc_q[EIDX_W-1:0]; e_wdata = e_rdata_q;
            kc_d = kc_q + 1'b1;
          end
        end
        n_re = n_more; ndv_d = n_more; ndi_d = nc_q[NIDX_W-1:0];
        if (n_more) nc_d = nc_q + 1'b1;
        e_re = e_more; edv_d = e_more; edi_d = ec_q[EIDX_W-1:0];
        if (e_more) ec_d = ec_q + 1'b1;
        if (scan_done) begin
          if (req_q == REQ_REM_NODE) nu_d = nu_q - 1'b1;
          eu_d = kc_q;
          state_d = S_EMIT;
        end
      end

      S_MD_N: begin
        if (ci_q < nu_q) begin
          n_re = 1'b1; n_raddr = ci_q[NIDX_W-1:0];
          state_d = S_MD_W;
        end else state_d = S_EMIT;
      end

      S_MD_W: begin
        xid_d = n_rdata_q.id; deg_d = '0; ec_d = '0;
        state_d = S_MD_E;
      end

      S_MD_E: begin
        if (edv_q && (e_rdata_q.first == xid_q || e_rdata_q.second == xid_q))
          deg_d = deg_q + 1'b1;
        e_re = e_more; edv_d = e_more; edi_d = ec_q[EIDX_W-1:0];
        if (e_more) ec_d = ec_q + 1'b1;
        if (e_idle) begin
          if (VALUE_W'(deg_q) > val_q) val_d = VALUE_W'(deg_q);
          ci_d = ci_q + 1'b1;
          state_d = S_MD_N;
        end
      end

      S_C_NI: begin
        n_re = 1'b1; n_raddr = ci_q[NIDX_W-1:0];
        state_d = S_C_IW;
      end

      S_C_IW: begin
        xid_d = n_rdata_q.id; taken_d = '0; cj_d = '0;
        state_d = S_C_NJ;
      end

      S_C_NJ: begin
        if (cj_q < nu_q) begin
          n_re = 1'b1; n_raddr = cj_q[NIDX_W-1:0];
          state_d = S_C_JW;
        end else state_d = S_C_OUT;
      end

      // Skip the node itself and nodes whose color cannot block
      S_C_JW: begin
        yid_d = n_rdata_q.id; ycol_d = n_rdata_q.color;
        if (n_rdata_q.id == xid_q || n_rdata_q.color == '0 ||
            n_rdata_q.color > COLOR_W'(MAX_NODES + 1)) begin
          cj_d = cj_q + 1'b1;
          state_d = S_C_NJ;
        end else begin
          ec_d = '0;
          state_d = S_C_E;
        end
      end

      // Look for any edge joining the two nodes, either direction
      S_C_E: begin
        e_re = e_more; edv_d = e_more; edi_d = ec_q[EIDX_W-1:0];
        if (e_more) ec_d = ec_q + 1'b1;
        if (hit || e_idle) begin
          if (hit) taken_d[ycol_q] = 1'b1;
          cj_d = cj_q + 1'b1;
          state_d = S_C_NJ;
        end
      end

      S_C_OUT: begin
        if (slot_free) begin
          n_we = 1'b1; n_waddr = ci_q[NIDX_W-1:0];
          n_wdata = '{id: xid_q, color: free_col};
          out_load = 1'b1; ol_status = STAT_OK; ol_value = VALUE_W'(free_col);
          ol_id = xid_q; ol_last = ((ci_q + NCNT_W'(1)) == nu_q);
          ci_d = ci_q + 1'b1;
          state_d = ol_last ? S_IDLE : S_C_NI;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (n_we) node_mem[n_waddr] <= n_wdata;
    if (n_re) n_rdata_q <= node_mem[n_raddr];
    if (e_we) edge_mem[e_waddr] <= e_wdata;
    if (e_re) e_rdata_q <= edge_mem[e_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; req_q <= '0; a_q <= '0; b_q <= '0;
      nu_q <= '0; eu_q <= '0;
      nc_q <= '0; ndv_q <= 1'b0; ndi_q <= '0;
      ec_q <= '0; edv_q <= 1'b0; edi_q <= '0; kc_q <= '0;
      fa_q <= 1'b0; fb_q <= 1'b0; ef_q <= 1'b0; fai_q <= '0; efi_q <= '0;
      deg_q <= '0; st_q <= '0; val_q <= '0;
      ci_q <= '0; cj_q <= '0; xid_q <= '0; yid_q <= '0; ycol_q <= '0;
      taken_q <= '0;
      out_valid_q <= 1'b0; out_status_q <= '0; out_value_q <= '0; out_id_q <= '0;
      out_nc_q <= '0; out_ec_q <= '0; out_last_q <= 1'b0;
    end else begin
      state_q <= state_d; req_q <= req_d; a_q <= a_d; b_q <= b_d;
      nu_q <= nu_d; eu_q <= eu_d;
      nc_q <= nc_d; ndv_q <= ndv_d; ndi_q <= ndi_d;
      ec_q <= ec_d; edv_q <= edv_d; edi_q <= edi_d; kc_q <= kc_d;
      fa_q <= fa_d; fb_q <= fb_d; ef_q <= ef_d; fai_q <= fai_d; efi_q <= efi_d;
      deg_q <= deg_d; st_q <= st_d; val_q <= val_d;
      ci_q <= ci_d; cj_q <= cj_d; xid_q <= xid_d; yid_q <= yid_d; ycol_q <= ycol_d;
      taken_q <= taken_d;
      // Output register: load a result, hold it until the transfer completes
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      if (out_load) begin
        out_status_q <= ol_status; out_value_q <= ol_value; out_id_q <= ol_id;
        out_nc_q <= nu_q; out_ec_q <= eu_q; out_last_q <= ol_last;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign value_o      = out_value_q;
  assign node_id_o    = out_id_q;
  assign node_count_o = out_nc_q;
  assign edge_count_o = out_ec_q;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  a_nodes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nu_q <= NCNT_W'(MAX_NODES)) else $error("node count above table size");
  a_edges_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eu_q <= ECNT_W'(MAX_EDGES)) else $error("edge count above table size");
  a_node_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(n_we && n_re && (n_waddr == n_raddr))) else $error("node memory read/write overlap");
  a_edge_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(e_we && e_re && (e_waddr == e_raddr))) else $error("edge memory read/write overlap");
`endif

endmodule
